// File: hdl/x86_64_page_table_walker_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page table walker
// Clocked checks with a synchronous reset that masks them.
// ---------------------------------------------------------------------------
`ifndef X86_64_PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define X86_64_PAGE_TABLE_WALKER_TOP_ASSERT_SVH

// Implication checked at every rising edge, masked while reset is high.
`define X86PW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold at every rising edge outside reset.
`define X86PW_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   `X86PW_ASSERT(lbl, clk, rst, 1'b1 |-> (cond), msg)

`endif

// File: hdl/x86pw_pkg.sv
// ---------------------------------------------------------------------------
// x86pw_pkg
// Shared types and codes of the four-level page table walker.
// ---------------------------------------------------------------------------
package x86pw_pkg;

   localparam int ADDR_W       = 52;
   localparam int VA_W         = 48;
   localparam int ENTRY_W      = 64;
   localparam int STATUS_W     = 4;
   localparam int REQ_TDATA_W  = 120;
   localparam int RSP_TDATA_W  = 112;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;

   // Request word tuser values
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_REPLY = 1'b1;

   // Result word tuser values
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Register indexes (byte address bits 4:3)
   localparam logic [1:0] REG_ROOT_BASE = 2'd0;
   localparam logic [1:0] REG_PAGING_ON = 2'd1;
   localparam logic [1:0] REG_PAE_ON    = 2'd2;
   localparam logic [1:0] REG_LONG_MODE = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 4'd0,
      ST_NO_PG    = 4'd1,
      ST_NO_PAE   = 4'd2,
      ST_NO_LME   = 4'd3,
      ST_NP_PML4  = 4'd4,
      ST_NP_PDPT  = 4'd5,
      ST_BIG_PAGE = 4'd6,
      ST_NP_PD    = 4'd7,
      ST_NP_PT    = 4'd8,
      ST_READ_ERR = 4'd9
   } status_type;

   typedef enum logic [4:0] {
      LVL_IDLE = 5'b00001,
      LVL_PML4 = 5'b00010,
      LVL_PDPT = 5'b00100,
      LVL_PD   = 5'b01000,
      LVL_PT   = 5'b10000
   } level_type;

   typedef struct packed {
      logic [ADDR_W-1:0] root_table_base;
      logic              paging_on;
      logic              pae_on;
      logic              long_mode_on;
   } cfg_type;

   typedef struct packed {
      logic              has_result;
      logic              kind;
      logic [ADDR_W-1:0] read_address;
      logic [ADDR_W-1:0] physical_address;
      status_type        status;
   } result_type;

endpackage

// File: hdl/x86pw_csr.sv
// ---------------------------------------------------------------------------
// x86pw_csr
// Control registers (CR3, PG, PAE, LME) behind the register bus.
// ---------------------------------------------------------------------------
module x86pw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [x86pw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [x86pw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [x86pw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output x86pw_pkg::cfg_type                  cfg
);

   x86pw_pkg::cfg_type cfg_ff;
   x86pw_pkg::cfg_type cfg_in;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:3];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            x86pw_pkg::REG_ROOT_BASE:
               cfg_in.root_table_base = csr_pwdata[x86pw_pkg::ADDR_W-1:0];
            x86pw_pkg::REG_PAGING_ON: cfg_in.paging_on    = csr_pwdata[0];
            x86pw_pkg::REG_PAE_ON:    cfg_in.pae_on       = csr_pwdata[0];
            x86pw_pkg::REG_LONG_MODE: cfg_in.long_mode_on = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         x86pw_pkg::REG_ROOT_BASE:
            csr_prdata = {12'd0, cfg_ff.root_table_base};
         x86pw_pkg::REG_PAGING_ON: csr_prdata = {63'd0, cfg_ff.paging_on};
         x86pw_pkg::REG_PAE_ON:    csr_prdata = {63'd0, cfg_ff.pae_on};
         x86pw_pkg::REG_LONG_MODE: csr_prdata = {63'd0, cfg_ff.long_mode_on};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/x86pw_walk.sv
// ---------------------------------------------------------------------------
// x86pw_walk
// Input register, walk level state and the per-word step logic.
// ---------------------------------------------------------------------------
`include "x86_64_page_table_walker_top_assert.svh"

module x86pw_walk #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [x86pw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                 req_tuser,
   input  x86pw_pkg::cfg_type                   cfg,
   input  logic                                 out_space,
   output logic                                 advance,
   output x86pw_pkg::result_type                res
);

   localparam logic [x86pw_pkg::ADDR_W-1:0] PHYS_MASK =
      x86pw_pkg::ADDR_W'((65'd1 << PHYS_ADDR_BITS) - 65'd1);
   localparam logic [x86pw_pkg::ADDR_W-1:0] BASE_MASK =
      PHYS_MASK & ~x86pw_pkg::ADDR_W'(12'hFFF);
   localparam logic [x86pw_pkg::ADDR_W-1:0] LARGE_MASK =
      ~x86pw_pkg::ADDR_W'(21'h1FFFFF);

   logic                                 in_valid_ff;
   logic                                 in_cmd_ff;
   logic [x86pw_pkg::VA_W-1:0]           in_va_ff;
   logic [x86pw_pkg::ENTRY_W-1:0]        in_entry_ff;
   logic                                 in_fail_ff;
   logic                                 in_valid_in;
   logic                                 take;

   x86pw_pkg::level_type                 level_ff;
   x86pw_pkg::level_type                 level_in;
   logic [x86pw_pkg::VA_W-1:0]           va_ff;
   logic [x86pw_pkg::VA_W-1:0]           va_in;

   logic [x86pw_pkg::ADDR_W-1:0]         base;
   logic                                 present;
   logic                                 big;

   assign advance    = in_valid_ff && (!res.has_result || out_space);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign base    = in_entry_ff[x86pw_pkg::ADDR_W-1:0] & BASE_MASK;
   assign present = in_entry_ff[0];
   assign big     = in_entry_ff[7];

   always_comb begin
      res          = '0;
      res.status   = x86pw_pkg::ST_OK;
      level_in     = level_ff;
      va_in        = va_ff;
      if (in_cmd_ff == x86pw_pkg::CMD_START) begin
         res.has_result = 1'b1;
         res.kind       = x86pw_pkg::KIND_DONE;
         level_in       = x86pw_pkg::LVL_IDLE;
         if (!cfg.paging_on) begin
            res.status = x86pw_pkg::ST_NO_PG;
         end else if (!cfg.pae_on) begin
            res.status = x86pw_pkg::ST_NO_PAE;
         end else if (!cfg.long_mode_on) begin
            res.status = x86pw_pkg::ST_NO_LME;
         end else begin
            res.kind         = x86pw_pkg::KIND_READ;
            va_in            = in_va_ff;
            level_in         = x86pw_pkg::LVL_PML4;
            res.read_address = (cfg.root_table_base & BASE_MASK) |
                               {40'd0, in_va_ff[47:39], 3'd0};
         end
      end else if (level_ff != x86pw_pkg::LVL_IDLE) begin
         res.has_result = 1'b1;
         res.kind       = x86pw_pkg::KIND_DONE;
         level_in       = x86pw_pkg::LVL_IDLE;
         if (in_fail_ff) begin
            res.status = x86pw_pkg::ST_READ_ERR;
         end else begin
            case (level_ff)
               x86pw_pkg::LVL_PML4: begin
                  if (!present) begin
                     res.status = x86pw_pkg::ST_NP_PML4;
                  end else begin
                     res.kind         = x86pw_pkg::KIND_READ;
                     level_in         = x86pw_pkg::LVL_PDPT;
                     res.read_address = base | {40'd0, va_ff[38:30], 3'd0};
                  end
               end
               x86pw_pkg::LVL_PDPT: begin
                  if (!present) begin
                     res.status = x86pw_pkg::ST_NP_PDPT;
                  end else if (big) begin
                     res.status = x86pw_pkg::ST_BIG_PAGE;
                  end else begin
                     res.kind         = x86pw_pkg::KIND_READ;
                     level_in         = x86pw_pkg::LVL_PD;
                     res.read_address = base | {40'd0, va_ff[29:21], 3'd0};
                  end
               end
               x86pw_pkg::LVL_PD: begin
                  if (!present) begin
                     res.status = x86pw_pkg::ST_NP_PD;
                  end else if (big) begin
                     res.physical_address = ((base & LARGE_MASK) |
                                             {31'd0, va_ff[20:0]}) & PHYS_MASK;
                  end else begin
                     res.kind         = x86pw_pkg::KIND_READ;
                     level_in         = x86pw_pkg::LVL_PT;
                     res.read_address = base | {40'd0, va_ff[20:12], 3'd0};
                  end
               end
               x86pw_pkg::LVL_PT: begin
                  if (!present) begin
                     res.status = x86pw_pkg::ST_NP_PT;
                  end else begin
                     res.physical_address = (base | {40'd0, va_ff[11:0]}) &
                                            PHYS_MASK;
                  end
               end
               default: begin
                  res.has_result = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         level_ff    <= x86pw_pkg::LVL_IDLE;
         va_ff       <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            level_ff <= level_in;
            va_ff    <= va_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_cmd_ff   <= req_tuser;
         in_va_ff    <= req_tdata[47:0];
         in_entry_ff <= req_tdata[111:48];
         in_fail_ff  <= req_tdata[112];
      end
   end

   `X86PW_ASSERT(a_idle_reply_silent, clock, reset,
      (in_valid_ff && in_cmd_ff == x86pw_pkg::CMD_REPLY &&
       level_ff == x86pw_pkg::LVL_IDLE) |-> !res.has_result,
      "reply while idle produced a result")
   `X86PW_ASSERT(a_disabled_start_idle, clock, reset,
      (advance && in_cmd_ff == x86pw_pkg::CMD_START && !cfg.paging_on) |=>
      (level_ff == x86pw_pkg::LVL_IDLE),
      "start with paging off left a walk pending")
   `X86PW_ASSERT(a_start_goes_pml4, clock, reset,
      (advance && in_cmd_ff == x86pw_pkg::CMD_START && cfg.paging_on &&
       cfg.pae_on && cfg.long_mode_on) |=> (level_ff == x86pw_pkg::LVL_PML4),
      "enabled start did not wait for the PML4 entry")
   `X86PW_ASSERT_ALWAYS(a_read_keeps_walk, clock, reset,
      !(advance && res.has_result && res.kind == x86pw_pkg::KIND_READ &&
        level_in == x86pw_pkg::LVL_IDLE),
      "read request issued while the walk went idle")

endmodule

// File: hdl/x86pw_out.sv
// ---------------------------------------------------------------------------
// x86pw_out
// Result register that holds a finished word until the sink takes it.
// ---------------------------------------------------------------------------
module x86pw_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  x86pw_pkg::result_type                res,
   output logic                                 out_space,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [x86pw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                 rsp_tuser
);

   logic                              valid_ff;
   logic                              valid_in;
   logic                              load;
   logic                              kind_ff;
   logic [x86pw_pkg::ADDR_W-1:0]      raddr_ff;
   logic [x86pw_pkg::ADDR_W-1:0]      paddr_ff;
   x86pw_pkg::status_type             status_ff;

   assign out_space = !valid_ff || rsp_tready;
   assign load      = advance && res.has_result;
   assign valid_in  = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {4'd0, status_ff, paddr_ff, raddr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= res.kind;
         raddr_ff  <= res.read_address;
         paddr_ff  <= res.physical_address;
         status_ff <= res.status;
      end
   end

endmodule

// File: hdl/x86_64_page_table_walker_top.sv
// ---------------------------------------------------------------------------
// x86_64_page_table_walker_top
// Four-level x86-64 page walker driven by request and memory-reply words.
// ---------------------------------------------------------------------------
// Send a start word (tuser 0, virtual address in tdata) to begin a walk; the
// block answers with one read request for the PML4 entry, or a finished word
// with an error status when paging, PAE or long mode is off. Feed each 8-byte
// entry back as a reply word (tuser 1); each reply yields the next read
// request or a finished word carrying the physical address (4 KB or 2 MB
// page) or a fault code. A start during a walk drops the pending walk; a
// reply while idle is dropped without a result. Every word is held in the input
// register, passes through combinational step logic and has its result loaded
// into the result register that drives rsp_tvalid; one word per cycle is
// sustained while rsp_tready keeps the result register free. The result
// register lets a new word enter while a finished one still waits for
// rsp_tready. Write control registers only while idle.
// ---------------------------------------------------------------------------
module x86_64_page_table_walker_top #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request words
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [47:0] virtual_address, [111:48] entry_word, [112] read_failed
   input  logic [x86pw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] command
   input  logic                                 req_tuser,
   // Result words
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [51:0] read_address, [103:52] physical_address, [107:104] status
   output logic [x86pw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] kind
   output logic                                 rsp_tuser,
   // Control registers
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [x86pw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [x86pw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [x86pw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   x86pw_pkg::cfg_type     cfg;
   x86pw_pkg::result_type  res;
   logic                   advance;
   logic                   out_space;

   // Hold CR3, PG, PAE and LME
   x86pw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Register the word, advance the walk level and form the result
   x86pw_walk #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .out_space  (out_space),
      .advance    (advance),
      .res        (res)
   );

   // Hold the finished word until the sink takes it
   x86pw_out u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .res        (res),
      .out_space  (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
